>>> hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the tag tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bbtt_pkg.sv
// Shared types and constants of the bracket-tag markup tokenizer.
package bbtt_pkg;

  localparam int MaxEvents = 4;
  localparam int EvIdxW    = 2;
  localparam int StateW    = 5;

  // Parser state codes
  localparam logic [StateW-1:0] ST_OPEN      = 5'd0;
  localparam logic [StateW-1:0] ST_CLOSE     = 5'd1;
  localparam logic [StateW-1:0] ST_NSOPEN    = 5'd2;
  localparam logic [StateW-1:0] ST_INNER     = 5'd3;
  localparam logic [StateW-1:0] ST_PRECLOSE  = 5'd4;
  localparam logic [StateW-1:0] ST_NSCLOSE   = 5'd5;
  localparam logic [StateW-1:0] ST_NAME      = 5'd6;
  localparam logic [StateW-1:0] ST_NAME_END  = 5'd7;
  localparam logic [StateW-1:0] ST_KEY       = 5'd8;
  localparam logic [StateW-1:0] ST_KEY_END   = 5'd9;
  localparam logic [StateW-1:0] ST_ASSIGN    = 5'd10;
  localparam logic [StateW-1:0] ST_QUOTE     = 5'd11;
  localparam logic [StateW-1:0] ST_VAL       = 5'd12;
  localparam logic [StateW-1:0] ST_VAL_END   = 5'd13;
  localparam logic [StateW-1:0] ST_TEXT      = 5'd14;
  localparam logic [StateW-1:0] ST_TEXT_END  = 5'd15;
  localparam logic [StateW-1:0] ST_RNAME     = 5'd16;
  localparam logic [StateW-1:0] ST_RNAME_END = 5'd17;
  localparam logic [StateW-1:0] ST_DONE      = 5'd30;
  localparam logic [StateW-1:0] ST_FAIL      = 5'd31;

  // Token event kinds
  localparam logic [3:0] EV_NAME_START  = 4'd0;
  localparam logic [3:0] EV_NAME_CHAR   = 4'd1;
  localparam logic [3:0] EV_NAME_DONE   = 4'd2;
  localparam logic [3:0] EV_KEY_START   = 4'd3;
  localparam logic [3:0] EV_KEY_CHAR    = 4'd4;
  localparam logic [3:0] EV_VAL_START   = 4'd5;
  localparam logic [3:0] EV_VAL_CHAR    = 4'd6;
  localparam logic [3:0] EV_ATTR_DONE   = 4'd7;
  localparam logic [3:0] EV_TEXT_START  = 4'd8;
  localparam logic [3:0] EV_TEXT_CHAR   = 4'd9;
  localparam logic [3:0] EV_TEXT_DONE   = 4'd10;
  localparam logic [3:0] EV_NEW_NODE    = 4'd11;
  localparam logic [3:0] EV_DOC_DONE    = 4'd12;
  localparam logic [3:0] EV_DOC_FAILED  = 4'd13;

  // Characters the parser reacts to
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef logic [3:0] kind_t;

  // All events of one character; every event carries the same character
  typedef struct packed {
    logic [7:0]                 ch;
    logic [EvIdxW-1:0]          last_idx;
    logic [MaxEvents-1:0][3:0]  kinds;
  } bundle_t;

endpackage

>>> hw/rtl/bbtt_front.sv
// Front end: parser state machine that turns one character into its event bundle.
module bbtt_front import bbtt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] char_code,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  typedef struct packed {
    logic [StateW-1:0] ns;
    logic              nxt;
  } step_t;

  logic [StateW-1:0] parse_state;
  logic [StateW-1:0] parse_state_next;
  logic              discarding;
  logic              discarding_next;

  logic              accept;
  logic [StateW-1:0] s;
  logic              stop;
  logic              disc_hit;
  logic [2:0]        cnt;
  logic [2:0]        cnt_eff;
  logic [MaxEvents-1:0][3:0] kinds;
  step_t             st;
  logic              e0_en;
  logic              e1_en;
  kind_t             e0_kind;

  // One transition of the parser for state s and character c
  function automatic step_t next_step(input logic [StateW-1:0] cs, input logic [7:0] c);
    logic  sp;
    logic  qt;
    logic  in_tag;
    step_t r;
    sp = (c == CH_SPACE) || (c == CH_TAB);
    qt = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    in_tag = cs inside {ST_OPEN, ST_NSOPEN, ST_PRECLOSE, [ST_NAME:ST_VAL_END],
                        ST_RNAME, ST_RNAME_END};
    r.ns  = ST_FAIL;
    r.nxt = 1'b0;
    if (in_tag && (c == CH_NUL)) begin
      r.ns = ST_FAIL;
    end else begin
      unique case (cs) inside
        ST_OPEN: begin
          if (sp) begin r.ns = ST_OPEN; r.nxt = 1'b1; end
          else if (c == CH_SLASH) begin r.ns = ST_PRECLOSE; r.nxt = 1'b1; end
          else r.ns = ST_NSOPEN;
        end
        ST_NSOPEN: begin
          if (sp) begin r.ns = ST_NSOPEN; r.nxt = 1'b1; end
          else r.ns = ST_NAME;
        end
        ST_NAME: begin
          if (sp || (c == CH_RBRACK) || (c == CH_SLASH)) r.ns = ST_NAME_END;
          else begin r.ns = ST_NAME; r.nxt = 1'b1; end
        end
        ST_NAME_END: begin
          if (sp) begin r.ns = ST_NAME_END; r.nxt = 1'b1; end
          else if (c == CH_RBRACK) begin r.ns = ST_INNER; r.nxt = 1'b1; end
          else if (c == CH_SLASH) begin r.ns = ST_PRECLOSE; r.nxt = 1'b1; end
          else r.ns = ST_KEY;
        end
        ST_KEY: begin
          if (sp || (c == CH_EQ)) r.ns = ST_KEY_END;
          else begin r.ns = ST_KEY; r.nxt = 1'b1; end
        end
        ST_KEY_END: begin
          if (sp) begin r.ns = ST_KEY_END; r.nxt = 1'b1; end
          else if (c == CH_EQ) begin r.ns = ST_ASSIGN; r.nxt = 1'b1; end
          else r.ns = ST_FAIL;
        end
        ST_ASSIGN: begin
          if (sp) begin r.ns = ST_ASSIGN; r.nxt = 1'b1; end
          else if (qt) begin r.ns = ST_QUOTE; r.nxt = 1'b1; end
          else r.ns = ST_FAIL;
        end
        ST_QUOTE: r.ns = ST_VAL;
        ST_VAL: begin
          if (qt) r.ns = ST_VAL_END;
          else begin r.ns = ST_VAL; r.nxt = 1'b1; end
        end
        ST_VAL_END: begin
          if (qt || sp) begin r.ns = ST_VAL_END; r.nxt = 1'b1; end
          else if (c == CH_SLASH) begin r.ns = ST_PRECLOSE; r.nxt = 1'b1; end
          else if (c == CH_RBRACK) begin r.ns = ST_INNER; r.nxt = 1'b1; end
          else r.ns = ST_KEY;
        end
        ST_INNER, ST_CLOSE: r.ns = ST_TEXT;
        ST_TEXT: begin
          if ((c == CH_LBRACK) || (c == CH_NUL)) r.ns = ST_TEXT_END;
          else begin r.ns = ST_TEXT; r.nxt = 1'b1; end
        end
        ST_TEXT_END: begin
          if (c == CH_LBRACK) begin r.ns = ST_OPEN; r.nxt = 1'b1; end
          else if (c == CH_NUL) r.ns = ST_DONE;
          else r.ns = ST_FAIL;
        end
        ST_PRECLOSE: begin
          if (c == CH_RBRACK) r.ns = ST_NSCLOSE;
          else r.ns = ST_RNAME;
        end
        ST_RNAME: begin
          if (c == CH_RBRACK) r.ns = ST_RNAME_END;
          else begin r.ns = ST_RNAME; r.nxt = 1'b1; end
        end
        ST_RNAME_END: begin
          if (c == CH_RBRACK) r.ns = ST_NSCLOSE;
          else r.ns = ST_FAIL;
        end
        ST_NSCLOSE: begin r.ns = ST_CLOSE; r.nxt = 1'b1; end
        default: r.ns = ST_FAIL;
      endcase
    end
    return r;
  endfunction

  assign accept = push && !q_full;

  // Walk the re-examine chain of one character, collecting up to four events
  always_comb begin
    s        = parse_state;
    stop     = 1'b0;
    disc_hit = 1'b0;
    cnt      = 3'd0;
    kinds    = '0;
    st       = '0;
    e0_en    = 1'b0;
    e1_en    = 1'b0;
    e0_kind  = EV_NAME_START;
    for (int i = 0; i < 8; i++) begin
      if (!stop) begin
        st      = next_step(s, char_code);
        e0_en   = 1'b0;
        e1_en   = 1'b0;
        e0_kind = EV_NAME_START;
        if ((st.ns == ST_DONE) || (st.ns == ST_FAIL)) begin
          e0_en    = 1'b1;
          e0_kind  = (st.ns == ST_DONE) ? EV_DOC_DONE : EV_DOC_FAILED;
          disc_hit = (st.ns == ST_FAIL) && (char_code != CH_NUL);
          s        = ST_TEXT;
          stop     = 1'b1;
        end else begin
          unique case (st.ns) inside
            ST_NAME: begin
              e0_en   = 1'b1;
              e0_kind = st.nxt ? EV_NAME_CHAR : EV_NAME_START;
            end
            ST_NAME_END: begin
              e0_en   = !st.nxt;
              e0_kind = EV_NAME_DONE;
            end
            ST_KEY: begin
              e0_en   = 1'b1;
              e0_kind = st.nxt ? EV_KEY_CHAR : EV_KEY_START;
            end
            ST_VAL: begin
              e0_en   = 1'b1;
              e0_kind = st.nxt ? EV_VAL_CHAR : EV_VAL_START;
            end
            ST_VAL_END: begin
              e0_en   = !st.nxt;
              e0_kind = EV_ATTR_DONE;
            end
            ST_TEXT: begin
              e0_en   = 1'b1;
              e0_kind = st.nxt ? EV_TEXT_CHAR : EV_TEXT_START;
            end
            ST_TEXT_END: begin
              e0_en   = !st.nxt;
              e0_kind = EV_TEXT_DONE;
              e1_en   = !st.nxt && (char_code != CH_NUL);
            end
            default: e0_en = 1'b0;
          endcase
          s = st.ns;
          if (st.nxt) stop = 1'b1;
        end
        // Append events, dropping any beyond the bundle size
        if (e0_en && (cnt < 3'(MaxEvents))) begin
          kinds[cnt[EvIdxW-1:0]] = e0_kind;
          cnt = cnt + 3'd1;
        end
        if (e1_en && (cnt < 3'(MaxEvents))) begin
          kinds[cnt[EvIdxW-1:0]] = EV_NEW_NODE;
          cnt = cnt + 3'd1;
        end
      end
    end
  end

  // Drop characters through the terminator after a failure
  always_comb begin
    if (discarding) begin
      cnt_eff          = 3'd0;
      discarding_next  = (char_code != CH_NUL);
      parse_state_next = (char_code == CH_NUL) ? ST_TEXT : parse_state;
    end else begin
      cnt_eff          = cnt;
      discarding_next  = disc_hit;
      parse_state_next = s;
    end
  end

  assign q_push        = accept && (cnt_eff != 3'd0);
  assign q_data.ch     = char_code;
  assign q_data.last_idx = EvIdxW'(cnt_eff - 3'd1);
  assign q_data.kinds  = kinds;

  // Advance the parser on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_TEXT;
      discarding  <= 1'b0;
    end else if (accept) begin
      parse_state <= parse_state_next;
      discarding  <= discarding_next;
    end
  end

endmodule

>>> hw/rtl/bbtt_queue.sv
// Short bundle queue that decouples the parser from the event output.
module bbtt_queue import bbtt_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output bundle_t rdata,
  output logic    empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  bundle_t         slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Store an incoming bundle
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

>>> hw/rtl/bbtt_back.sv
// Back end: hands out the events of each bundle one transaction at a time.
module bbtt_back import bbtt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  bundle_t    q_data,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] event_kind,
  output logic [7:0] event_char,
  output logic       last_of_item
);

  bundle_t           cur;
  logic              cur_valid;
  logic [EvIdxW-1:0] idx;
  logic              take;
  logic              finish;
  logic              load;

  assign take   = pop && cur_valid;
  assign finish = take && (idx == cur.last_idx);
  assign load   = !q_empty && (!cur_valid || finish);
  assign q_pop  = load;

  assign empty        = !cur_valid;
  assign event_kind   = cur.kinds[idx];
  assign event_char   = cur.ch;
  assign last_of_item = (idx == cur.last_idx);

  // Hold the bundle being delivered
  always_ff @(posedge clk) begin
    if (load) cur <= q_data;
  end

  // Step through the events, refilling from the queue after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (finish) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

>>> hw/rtl/bbcode_tag_tokenizer.sv
// Top level of the bracket-tag markup tokenizer.
//
// Input channel: one document character per transaction on char_code, taken
// when push is high and full is low. A zero character ends the document.
// Result channel: token events, oldest first, shown while empty is low and
// taken when pop is high. Each character yields zero to four events; the
// final one of a character carries last_of_item, and event_char always holds
// that character.
// Path: the events of a character are first written into the bundle queue and
// then loaded into the back-end bundle register before they show on the ports.
// Throughput: one character per cycle while the bundle queue has room, and one
// event per cycle on the result side while pop is high; the event stepper in
// the back end sets the sustained rate.
// When the receiver stalls, the current event holds and up to QUEUE_DEPTH
// bundles gather before full rises. Reset empties the queue and returns the
// parser to the text state with discarding cleared.
module bbcode_tag_tokenizer import bbtt_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] event_kind,
  output logic [7:0] event_char,
  output logic       last_of_item
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_wdata;
  bundle_t q_rdata;

  assign full = q_full;

  // Parse characters into event bundles
  bbtt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Buffer bundles between the two sides
  bbtt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Deliver events one at a time
  bbtt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .event_kind   (event_kind),
    .event_char   (event_char),
    .last_of_item (last_of_item)
  );

endmodule

>>> hw/rtl/bbtt_checker.sv
// Port-level checks of the tag tokenizer and their binding to the top level.
`include "assert_macros.svh"

module bbtt_checker import bbtt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [3:0] event_kind,
  input logic [7:0] event_char,
  input logic       last_of_item
);

  // Reset leaves no result waiting
  `ASSERT_CLK_NR(a_reset_empty, clk, rst |=> empty, "result pending after reset")

  // Only defined event kinds leave the block
  `ASSERT_CLK(a_kind_range, clk, rst, !empty |-> (event_kind <= EV_DOC_FAILED), "undefined event kind")

  // Document done and failed always close their character
  `ASSERT_CLK(a_end_is_last, clk, rst,
    (!empty && ((event_kind == EV_DOC_DONE) || (event_kind == EV_DOC_FAILED))) |-> last_of_item,
    "document end event not last of its character")

  // A stalled result holds its payload
  `ASSERT_CLK(a_stall_hold, clk, rst,
    (!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(event_char)
      && $stable(last_of_item)),
    "stalled result changed")

endmodule

bind bbcode_tag_tokenizer bbtt_checker u_checker (.*);
